FILE: hw/rtl/smac_pkg.sv
// Shared types and constants for the sliding median / absolute cost block.
package smac_pkg;

   // Field widths
   localparam int SAMPLE_W = 32;
   localparam int COST_W   = 36;
   localparam int LEN_W    = 6;

   // Window length after reset (before clamping to the window capacity)
   localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

   // Per-cycle command to the row of sorted cells
   typedef struct packed {
      logic clear;   // drop all samples
      logic del;     // remove the oldest sample, close the gap
      logic ins;     // insert the held sample at its sorted place
   } cell_ctl_type;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INSERT = 5'b00010,
      ST_MEDIAN = 5'b00100,
      ST_SUM    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

FILE: hw/rtl/smac_cell.sv
// One sorted cell: holds a sample and its age, shifts with its neighbors.
module smac_cell #(
   parameter int IDX = 0,
   parameter int AW  = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  smac_pkg::cell_ctl_type             ctl,
   input  logic [smac_pkg::SAMPLE_W-1:0]      sample,
   input  logic [smac_pkg::SAMPLE_W-1:0]      evict_val,
   input  logic [AW-1:0]                      last_age,
   input  logic [AW-1:0]                      mid,
   input  logic [smac_pkg::SAMPLE_W-1:0]      med,
   // left neighbor (smaller side)
   input  logic [smac_pkg::SAMPLE_W-1:0]      left_val,
   input  logic                               left_valid,
   input  logic [AW-1:0]                      left_age,
   input  logic                               left_ge,
   // right neighbor (larger side)
   input  logic [smac_pkg::SAMPLE_W-1:0]      right_val,
   input  logic                               right_valid,
   input  logic [AW-1:0]                      right_age,
   output logic [smac_pkg::SAMPLE_W-1:0]      val,
   output logic                               valid,
   output logic [AW-1:0]                      age,
   output logic                               ge,
   output logic [smac_pkg::SAMPLE_W-1:0]      evict_tap,
   output logic [smac_pkg::SAMPLE_W-1:0]      med_tap,
   output logic [smac_pkg::SAMPLE_W-1:0]      diff
);

   logic [smac_pkg::SAMPLE_W-1:0] val_ff, val_in;
   logic                          valid_ff, valid_in;
   logic [AW-1:0]                 age_ff, age_in;
   logic [smac_pkg::SAMPLE_W-1:0] diff_ff, diff_in;
   logic                          shift_del;
   logic                          is_oldest;

   // Empty cells count as larger than anything
   assign ge        = !valid_ff || (val_ff >= sample);
   assign is_oldest = valid_ff && (age_ff == last_age);
   // Equal values sit youngest first, so the oldest one closes its run
   assign shift_del = !valid_ff || (val_ff > evict_val) ||
                      ((val_ff == evict_val) && (age_ff == last_age));

   // Next content of the cell
   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      age_in   = age_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.del && shift_del) begin
         val_in   = right_val;
         valid_in = right_valid;
         age_in   = right_age;
      end else if (ctl.ins) begin
         if (left_ge) begin
            val_in   = left_val;
            valid_in = left_valid;
            age_in   = left_age + AW'(1);
         end else if (ge) begin
            val_in   = sample;
            valid_in = 1'b1;
            age_in   = '0;
         end else begin
            age_in   = age_ff + AW'(1);
         end
      end
   end

   // Distance to the median, zero for empty cells
   always_comb begin
      if (!valid_ff) begin
         diff_in = '0;
      end else if (val_ff >= med) begin
         diff_in = val_ff - med;
      end else begin
         diff_in = med - val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff  <= val_in;
      age_ff  <= age_in;
      diff_ff <= diff_in;
   end

   assign val       = val_ff;
   assign valid     = valid_ff;
   assign age       = age_ff;
   assign evict_tap = is_oldest ? val_ff : '0;
   assign med_tap   = (valid_ff && (mid == AW'(IDX))) ? val_ff : '0;
   assign diff      = diff_ff;

endmodule

FILE: hw/rtl/smac_sum_tree.sv
// Registered binary adder tree, one register level per tree level.
module smac_sum_tree #(
   parameter int N  = 32,
   parameter int IW = 32
) (
   input  logic                                        clock,
   input  logic [IW-1:0]                               leaf_in [N],
   output logic [IW+((N > 1) ? $clog2(N) : 0)-1:0]     sum
);

   localparam int LEVELS = (N > 1) ? $clog2(N) : 0;
   localparam int P      = 1 << LEVELS;
   localparam int OW     = IW + LEVELS;

   logic [OW-1:0] leaf_w [P];

   // Leaves, padded with zeros up to a power of two
   for (genvar j = 0; j < P; j++) begin : g_leaf
      if (j < N) begin : g_used
         assign leaf_w[j] = OW'(leaf_in[j]);
      end else begin : g_pad
         assign leaf_w[j] = '0;
      end
   end

   if (P > 1) begin : g_tree
      logic [OW-1:0] sum_ff [1:P-1];

      // Heap-ordered nodes: node k adds nodes 2k and 2k+1
      for (genvar k = 1; k < P; k++) begin : g_node
         if (2 * k >= P) begin : g_bottom
            always_ff @(posedge clock) begin
               sum_ff[k] <= leaf_w[2*k-P] + leaf_w[2*k+1-P];
            end
         end else begin : g_inner
            always_ff @(posedge clock) begin
               sum_ff[k] <= sum_ff[2*k] + sum_ff[2*k+1];
            end
         end
      end

      assign sum = sum_ff[1];
   end else begin : g_single
      assign sum = leaf_w[0];
   end

endmodule

FILE: hw/rtl/sliding_median_abs_cost.sv
// Top level: sliding window median and sum of absolute deviations.
//
// Each accepted sample enters a window of window_len samples (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX). The window is kept in a row of WINDOW_MAX sorted cells:
// at the transfer the oldest sample drops out and the row closes the gap, the next cycle
// inserts the new sample in order. Once the window is full, every sample produces one
// result: the lower median (rank (L+1)/2) and the sum of |sample - median| over the window,
// 36 bits. An item that yields no result passes the insert step only; an item that
// yields a result then passes the median select, the per-cell distance register and
// the registered adder tree. The input stalls until the item is through.
// A finished result sits in the output register while the next sample is taken.
// start_req or a write of window_len empties the window.
module sliding_median_abs_cost #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smac_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                req_start_req,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [smac_pkg::SAMPLE_W-1:0]       rsp_median,
   output logic [smac_pkg::COST_W-1:0]         rsp_cost,
   // window length register
   input  logic                                csr_wr_en,
   input  logic [smac_pkg::LEN_W-1:0]          csr_wr_data
);

   localparam int LW     = $clog2(WINDOW_MAX + 1);
   localparam int TL     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 0;
   localparam int AW     = (TL > 0) ? TL : 1;
   localparam int CNTW   = $clog2(TL + 2);
   localparam int SUM_W  = smac_pkg::SAMPLE_W + TL;
   localparam int EW     = (SUM_W > smac_pkg::COST_W) ? SUM_W : smac_pkg::COST_W;

   // Effective window length from the register value
   function automatic logic [LW-1:0] clamp_len(input logic [smac_pkg::LEN_W-1:0] v);
      int n;
      n = int'(v);
      if (n == 0) begin
         n = 1;
      end else if (n > WINDOW_MAX) begin
         n = WINDOW_MAX;
      end
      return LW'(n);
   endfunction

   smac_pkg::state_type            state_ff, state_in;
   logic [LW-1:0]                  len_ff, len_in;
   logic [LW-1:0]                  count_ff, count_in;
   logic [CNTW-1:0]                cnt_ff, cnt_in;
   logic [smac_pkg::SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [smac_pkg::SAMPLE_W-1:0]  med_ff, med_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [smac_pkg::SAMPLE_W-1:0]  rsp_median_ff, rsp_median_in;
   logic [smac_pkg::COST_W-1:0]    rsp_cost_ff, rsp_cost_in;

   logic                           accept;
   logic                           out_free;
   smac_pkg::cell_ctl_type         ctl;
   logic [AW-1:0]                  last_age;
   logic [AW-1:0]                  mid;
   logic [smac_pkg::SAMPLE_W-1:0]  evict_val;
   logic [smac_pkg::SAMPLE_W-1:0]  med_sel;
   logic [SUM_W-1:0]               tree_sum;
   logic [EW-1:0]                  cost_wide;

   logic [smac_pkg::SAMPLE_W-1:0]  cell_val   [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]          cell_valid;
   logic [AW-1:0]                  cell_age   [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]          cell_ge;
   logic [smac_pkg::SAMPLE_W-1:0]  evict_tap  [WINDOW_MAX];
   logic [smac_pkg::SAMPLE_W-1:0]  med_tap    [WINDOW_MAX];
   logic [smac_pkg::SAMPLE_W-1:0]  cell_diff  [WINDOW_MAX];

   // Handshakes
   assign req_stall = (state_ff != smac_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Window geometry
   assign last_age = AW'(len_ff - LW'(1));
   assign mid      = AW'((len_ff - LW'(1)) >> 1);

   // Cell commands
   always_comb begin
      ctl.clear = csr_wr_en || (accept && req_start_req);
      ctl.del   = accept && !req_start_req && (count_ff == len_ff);
      ctl.ins   = (state_ff == smac_pkg::ST_INSERT);
   end

   // Oldest sample and median pulled from the row
   always_comb begin
      evict_val = '0;
      med_sel   = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         evict_val = evict_val | evict_tap[i];
         med_sel   = med_sel | med_tap[i];
      end
   end

   // Row of sorted cells
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [smac_pkg::SAMPLE_W-1:0] lv, rv;
      logic                          lvalid, rvalid, lge;
      logic [AW-1:0]                 lage, rage;

      if (i == 0) begin : g_first
         assign lv     = '0;
         assign lvalid = 1'b0;
         assign lage   = '0;
         assign lge    = 1'b0;
      end else begin : g_mid_l
         assign lv     = cell_val[i-1];
         assign lvalid = cell_valid[i-1];
         assign lage   = cell_age[i-1];
         assign lge    = cell_ge[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign rv     = '0;
         assign rvalid = 1'b0;
         assign rage   = '0;
      end else begin : g_mid_r
         assign rv     = cell_val[i+1];
         assign rvalid = cell_valid[i+1];
         assign rage   = cell_age[i+1];
      end

      smac_cell #(
         .IDX (i),
         .AW  (AW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .sample      (sample_ff),
         .evict_val   (evict_val),
         .last_age    (last_age),
         .mid         (mid),
         .med         (med_ff),
         .left_val    (lv),
         .left_valid  (lvalid),
         .left_age    (lage),
         .left_ge     (lge),
         .right_val   (rv),
         .right_valid (rvalid),
         .right_age   (rage),
         .val         (cell_val[i]),
         .valid       (cell_valid[i]),
         .age         (cell_age[i]),
         .ge          (cell_ge[i]),
         .evict_tap   (evict_tap[i]),
         .med_tap     (med_tap[i]),
         .diff        (cell_diff[i])
      );
   end

   // Sum of distances
   smac_sum_tree #(
      .N  (WINDOW_MAX),
      .IW (smac_pkg::SAMPLE_W)
   ) u_sum_tree (
      .clock   (clock),
      .leaf_in (cell_diff),
      .sum     (tree_sum)
   );

   assign cost_wide = EW'(tree_sum);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      count_in      = count_ff;
      cnt_in        = cnt_ff;
      sample_in     = sample_ff;
      med_in        = med_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_median_in = rsp_median_ff;
      rsp_cost_in   = rsp_cost_ff;

      unique case (state_ff)
         smac_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               state_in  = smac_pkg::ST_INSERT;
               if (req_start_req) begin
                  count_in = '0;
               end else if (count_ff == len_ff) begin
                  count_in = count_ff - LW'(1);
               end
            end
         end
         smac_pkg::ST_INSERT: begin
            count_in = count_ff + LW'(1);
            state_in = (count_in == len_ff) ? smac_pkg::ST_MEDIAN : smac_pkg::ST_IDLE;
         end
         smac_pkg::ST_MEDIAN: begin
            med_in   = med_sel;
            cnt_in   = CNTW'(TL + 1);
            state_in = smac_pkg::ST_SUM;
         end
         smac_pkg::ST_SUM: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               state_in = smac_pkg::ST_DONE;
            end
         end
         smac_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = med_ff;
               rsp_cost_in   = cost_wide[smac_pkg::COST_W-1:0];
               state_in      = smac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smac_pkg::ST_IDLE;
         end
      endcase

      // Length write empties the window
      if (csr_wr_en) begin
         len_in   = clamp_len(csr_wr_data);
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smac_pkg::ST_IDLE;
         len_ff       <= clamp_len(smac_pkg::LEN_RESET);
         count_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      med_ff        <= med_in;
      rsp_median_ff <= rsp_median_in;
      rsp_cost_ff   <= rsp_cost_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_cost   = rsp_cost_ff;

`ifndef SYNTHESIS
   // Fill count never passes the window length
   a_count_le_len: assert property (@(posedge clock) disable iff (reset)
      count_ff <= len_ff)
      else $error("fill count above window length");

   // Occupied cells match the fill count
   a_cells_match_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("occupied cells differ from fill count");

   // A result is only finished from a full window
   a_done_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == smac_pkg::ST_DONE |-> count_ff == len_ff)
      else $error("result from a window that is not full");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the sliding window median and absolute-deviation cost block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_CAP      = 32;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 128;
   localparam int MAX_REPORTS  = 40;

   typedef struct {
      logic [smac_pkg::SAMPLE_W-1:0] median;
      logic [smac_pkg::COST_W-1:0]   cost;
   } median_cost_type;

   // Window tracker: mirrors the sample window and queues the expected median/cost pairs
   class median_cost_board_type;
      logic [smac_pkg::SAMPLE_W-1:0] window[WIN_CAP];
      int unsigned                   fill;
      int unsigned                   oldest;
      logic [smac_pkg::LEN_W-1:0]    len_reg;
      median_cost_type               pending[$];
      int                            errors;

      function new();
         len_reg = smac_pkg::LEN_RESET;
         fill    = 0;
         oldest  = 0;
         errors  = 0;
      endfunction

      // 0 acts as 1, anything above capacity acts as the capacity
      function int unsigned active_len();
         if (len_reg == 0) return 1;
         if (len_reg > WIN_CAP) return WIN_CAP;
         return 32'(len_reg);
      endfunction

      // a length write always empties the window
      function void rewrite_length(logic [smac_pkg::LEN_W-1:0] v);
         len_reg = v;
         fill    = 0;
         oldest  = 0;
      endfunction

      function void take_sample(logic [smac_pkg::SAMPLE_W-1:0] s, logic start);
         logic [smac_pkg::SAMPLE_W-1:0] ranked[WIN_CAP];
         logic [smac_pkg::SAMPLE_W-1:0] v;
         longint unsigned               dev_sum;
         median_cost_type               r;
         int unsigned                   n;
         int unsigned                   i;
         int unsigned                   j;
         n = active_len();
         if (start) begin
            fill   = 0;
            oldest = 0;
         end
         // fill, then overwrite the oldest slot
         if (fill < n) begin
            window[fill] = s;
            fill++;
         end else begin
            window[oldest] = s;
            oldest++;
            if (oldest >= n) oldest = 0;
         end
         if (fill < n) return;
         // ascending order of the window
         for (i = 0; i < n; i++) begin
            v = window[i];
            j = i;
            while (j > 0 && ranked[j-1] > v) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = v;
         end
         r.median = ranked[(n + 1) / 2 - 1];
         dev_sum  = 0;
         for (i = 0; i < n; i++) begin
            if (ranked[i] >= r.median) dev_sum += ranked[i] - r.median;
            else dev_sum += r.median - ranked[i];
         end
         r.cost  = dev_sum[smac_pkg::COST_W-1:0];
         pending = {pending, r};
      endfunction

      function void check_result(logic [smac_pkg::SAMPLE_W-1:0] median,
                                 logic [smac_pkg::COST_W-1:0] cost);
         median_cost_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual median %h cost %h",
                        $time, median, cost);
            return;
         end
         e = pending.pop_front();
         if (e.median !== median) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: median mismatch, expected %h actual %h",
                        $time, e.median, median);
         end
         if (e.cost !== cost) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: cost mismatch, expected %h actual %h", $time, e.cost, cost);
         end
      endfunction
   endclass

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic [smac_pkg::SAMPLE_W-1:0] req_sample    = '0;
   logic                          req_start_req = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic [smac_pkg::SAMPLE_W-1:0] rsp_median;
   logic [smac_pkg::COST_W-1:0]   rsp_cost;
   logic                          csr_wr_en     = 1'b0;
   logic [smac_pkg::LEN_W-1:0]    csr_wr_data   = '0;

   median_cost_board_type board;
   int                    req_idle_pct = 0;
   int                    rsp_idle_pct = 0;
   int                    hold_asks    = 0;
   int                    hold_seen    = 0;
   int                    hold_left    = 0;
   int unsigned           cycles       = 0;

   sliding_median_abs_cost #(.WINDOW_MAX(WIN_CAP)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_median    (rsp_median),
      .rsp_cost      (rsp_cost),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("sliding_median_abs_cost regression: fail");
         $finish;
      end
   end

   // result side stall: random, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_median, rsp_cost);
   end

   // one sample transfer, with idle cycles ahead of it at the sender's idle rate
   task automatic send_sample(input logic [smac_pkg::SAMPLE_W-1:0] s, input logic st);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= s;
      req_start_req <= st;
      do @(posedge clock); while (req_stall);
      board.take_sample(s, st);
   endtask

   // stop offering and wait until every expected result has left the block
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [smac_pkg::LEN_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.rewrite_length(v);
   endtask

   // full range, ties near zero, values near the top, coarse spread
   function automatic logic [smac_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 15);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom_range(0, 7) << 29;
      endcase
   endfunction

   initial begin
      logic [smac_pkg::LEN_W-1:0] phase_len[9];
      int unsigned                n;
      int                         p;
      int                         k;
      phase_len = '{6'd32, 6'd1, 6'd5, 6'd0, 6'd63, 6'd2, 6'd33, 6'd17, 6'd9};
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero length acts as one: every sample gives a result
      write_length(6'd0);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b1);
      drain();

      // length three: filling, sliding, restart mid-window
      write_length(6'd3);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0007, 1'b0);
      send_sample(32'h0000_0005, 1'b0);
      send_sample(32'h0000_0001, 1'b1);
      send_sample(32'h0000_0002, 1'b0);
      send_sample(32'h0000_0003, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      drain();

      // even length: lower median, widest spread
      write_length(6'd2);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      drain();

      // a rewrite of the length drops a partly filled window
      write_length(6'd4);
      send_sample(32'h0000_0009, 1'b0);
      send_sample(32'h0000_0008, 1'b0);
      send_sample(32'h0000_0007, 1'b0);
      drain();
      write_length(6'd4);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h0000_0002, 1'b0);
      send_sample(32'h0000_0003, 1'b0);
      send_sample(32'h0000_0004, 1'b0);

      // random phases over several lengths and idling mixes
      for (p = 0; p < 9; p++) begin
         drain();
         if (p < 3) begin
            req_idle_pct = 26;
            rsp_idle_pct = 58;
         end else if (p < 6) begin
            req_idle_pct = 58;
            rsp_idle_pct = 26;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_length(phase_len[p]);
         n = board.active_len();
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 6 && k == 40) hold_asks <= hold_asks + 1;
            send_sample(pick_sample(), $urandom_range(0, 4 * n + 3) == 0);
         end
      end
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("sliding_median_abs_cost regression: pass");
      end else begin
         $display("sliding_median_abs_cost regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/smac_pkg.sv
hw/rtl/smac_cell.sv
hw/rtl/smac_sum_tree.sv
hw/rtl/sliding_median_abs_cost.sv
tb/tb.sv
